// File: hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Types, constants and the commutation step table shared by the sensorless
// BLDC commutator.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam logic [7:0]  TEST_PULSE      = 8'd100;
    localparam logic [15:0] STARTUP_MARGIN  = 16'd1000;
    localparam logic [1:0]  MISS_LIMIT      = 2'd2;
    localparam logic [15:0] REF_PERIOD_RST  = 16'd2000;
    localparam logic [7:0]  POWER_CEIL_RST  = 8'd150;
    localparam logic [15:0] DEADLINE_RST    = 16'hFFFF;
    localparam logic [7:0]  POWER_RST       = 8'd1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        MODE_NONE         = 3'd0,
        MODE_AFTER_CROSS  = 3'd1,
        MODE_AFTER_SWITCH = 3'd2,
        MODE_WAIT_CONV    = 3'd3,
        MODE_PAUSE        = 3'd4,
        MODE_WAIT_CROSS   = 3'd5,
        MODE_TEST         = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        EV_DEADLINE = 2'd0,
        EV_CHECK    = 2'd1,
        EV_CONV     = 2'd2,
        EV_CROSS    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_REF_PERIOD = 2'd0,
        CFG_POWER_CEIL = 2'd1,
        CFG_START_TEST = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  step;
        logic [2:0]  high_legs;
        logic [2:0]  low_legs;
        logic [1:0]  sense_sel;
        logic        edge_sel;
        logic [7:0]  power;
        logic [1:0]  miss_count;
        logic [15:0] deadline;
        logic [15:0] speed_avg;
        logic        led;
    } state_t;

    localparam state_t STATE_RST = '{
        mode:       MODE_TEST,
        step:       3'd0,
        high_legs:  3'd0,
        low_legs:   3'd0,
        sense_sel:  2'd0,
        edge_sel:   1'b1,
        power:      POWER_RST,
        miss_count: 2'd0,
        deadline:   DEADLINE_RST,
        speed_avg:  16'd0,
        led:        1'b0
    };

    typedef struct packed {
        logic [2:0]  phase_step;
        logic [2:0]  high_leg_mask;
        logic [2:0]  low_leg_mask;
        logic [7:0]  pulse_width;
        logic [1:0]  sense_channel;
        logic        rising_edge;
        logic [15:0] deadline;
        logic        restart_timer;
        logic        arm_check;
        logic [15:0] speed_estimate;
        logic        fault_led;
        logic [2:0]  mode;
    } result_t;

    typedef struct packed {
        logic [2:0] next_step;
        logic [2:0] high_legs;
        logic [2:0] low_legs;
        logic [1:0] sense_sel;
        logic       edge_sel;
    } step_entry_t;

    // Bridge pattern per step; legs U=1, V=2, W=4. Unused steps behave as step 0.
    function automatic step_entry_t step_entry(input logic [2:0] step);
        step_entry_t e;
        unique case (step)
            3'd1:    e = '{3'd2, 3'd1, 3'd4, 2'd1, 1'b0};
            3'd2:    e = '{3'd3, 3'd2, 3'd4, 2'd0, 1'b1};
            3'd3:    e = '{3'd4, 3'd2, 3'd1, 2'd2, 1'b0};
            3'd4:    e = '{3'd5, 3'd4, 3'd1, 2'd1, 1'b1};
            3'd5:    e = '{3'd0, 3'd4, 3'd2, 2'd0, 1'b0};
            default: e = '{3'd1, 3'd1, 3'd2, 2'd2, 1'b1};
        endcase
        return e;
    endfunction

endpackage

// File: hw/rtl/sbc_event_logic.sv
// ----------------------------------------------------------------------------
// sbc_event_logic
// Next-state and result logic for one timing event: commutation, pulse
// scheduling, zero-cross deadline and power adjust, speed filter.
// ----------------------------------------------------------------------------
module sbc_event_logic #(
    parameter int TIMER_WIDTH = sbc_pkg::TIMER_WIDTH_DEF
) (
    input  sbc_pkg::state_t  cur,
    input  logic [15:0]      ref_period,
    input  logic [7:0]       power_ceiling,
    input  sbc_pkg::kind_t   kind,
    input  logic [15:0]      elapsed_ticks,
    input  logic             timer_wrapped,
    output sbc_pkg::state_t  nxt,
    output sbc_pkg::result_t result
);

    // sums wrap at the timer width, then land in 16 bits
    localparam logic [16:0] SUM_MASK = (TIMER_WIDTH >= 17) ? 17'h1FFFF :
                                       17'((33'd1 << TIMER_WIDTH) - 33'd1);

    sbc_pkg::step_entry_t ent;
    sbc_pkg::state_t      upd;
    logic [15:0] t;
    logic [15:0] thr;
    logic [15:0] half;
    logic [16:0] sum_margin;
    logic [16:0] sum_double;
    logic [18:0] avg_x7;
    logic [18:0] avg_sum;
    logic [7:0]  pulse;
    logic        restart;
    logic        arm;
    logic        commutate;

    assign ent        = sbc_pkg::step_entry(cur.step);
    assign t          = timer_wrapped ? 16'd0 : elapsed_ticks;
    assign thr        = ref_period - sbc_pkg::STARTUP_MARGIN;
    assign half       = ref_period >> 1;
    assign sum_margin = ({1'b0, t} + {1'b0, sbc_pkg::STARTUP_MARGIN}) & SUM_MASK;
    assign sum_double = ({1'b0, t} + {1'b0, t}) & SUM_MASK;

    always_comb
    begin
        upd       = cur;
        pulse     = 8'd0;
        restart   = 1'b0;
        arm       = 1'b0;
        commutate = 1'b0;
        unique case (kind)
            sbc_pkg::EV_DEADLINE:
            begin
                case (cur.mode)
                    sbc_pkg::MODE_AFTER_CROSS:
                    begin
                        upd.led   = 1'b0;
                        commutate = 1'b1;
                        if (cur.miss_count != 2'd0)
                            upd.miss_count = cur.miss_count - 2'd1;
                    end
                    sbc_pkg::MODE_WAIT_CROSS:
                    begin
                        upd.led = 1'b1;
                        if (cur.miss_count < sbc_pkg::MISS_LIMIT)
                        begin
                            commutate      = 1'b1;
                            upd.miss_count = cur.miss_count + 2'd1;
                        end
                        else if (cur.power != 8'd0)
                            upd.power = cur.power - 8'd1;
                    end
                    sbc_pkg::MODE_TEST:
                    begin
                        commutate = 1'b1;
                        pulse     = sbc_pkg::TEST_PULSE;
                    end
                    default: ;
                endcase
            end
            sbc_pkg::EV_CHECK:
            begin
                case (cur.mode)
                    sbc_pkg::MODE_AFTER_SWITCH:
                    begin
                        pulse    = cur.power;
                        upd.mode = sbc_pkg::MODE_WAIT_CONV;
                    end
                    sbc_pkg::MODE_PAUSE:
                        upd.mode = sbc_pkg::MODE_WAIT_CROSS;
                    default: ;
                endcase
            end
            sbc_pkg::EV_CONV:
            begin
                if (cur.mode == sbc_pkg::MODE_WAIT_CONV)
                begin
                    upd.mode = sbc_pkg::MODE_PAUSE;
                    arm      = 1'b1;
                end
            end
            sbc_pkg::EV_CROSS:
            begin
                if (cur.mode == sbc_pkg::MODE_WAIT_CROSS)
                begin
                    upd.mode = sbc_pkg::MODE_AFTER_CROSS;
                    if (t > thr)
                    begin
                        upd.deadline = sum_margin[15:0];
                        if (cur.power < power_ceiling)
                            upd.power = cur.power + 8'd1;
                    end
                    else if (t > half)
                    begin
                        upd.deadline = ref_period;
                        if (cur.power < power_ceiling)
                            upd.power = cur.power + 8'd1;
                    end
                    else if (t < half)
                    begin
                        upd.deadline = sum_double[15:0];
                        if (cur.power != 8'd0)
                            upd.power = cur.power - 8'd1;
                    end
                end
            end
        endcase

        if (commutate)
        begin
            upd.step      = ent.next_step;
            upd.high_legs = ent.high_legs;
            upd.low_legs  = ent.low_legs;
            upd.sense_sel = ent.sense_sel;
            upd.edge_sel  = ent.edge_sel;
            restart       = 1'b1;
            // test mode stays put and fires no check
            if (cur.mode != sbc_pkg::MODE_TEST)
            begin
                upd.mode = sbc_pkg::MODE_AFTER_SWITCH;
                arm      = 1'b1;
            end
        end
    end

    // speed filter: (7*avg + deadline) / 8 on the updated deadline, no wrap
    assign avg_x7  = {cur.speed_avg, 3'b000} - {3'b000, cur.speed_avg};
    assign avg_sum = avg_x7 + {3'b000, upd.deadline};

    always_comb
    begin
        nxt = upd;
        if (kind == sbc_pkg::EV_CROSS)
            nxt.speed_avg = avg_sum[18:3];
    end

    always_comb
    begin
        result = '{
            phase_step:     nxt.step,
            high_leg_mask:  nxt.high_legs,
            low_leg_mask:   nxt.low_legs,
            pulse_width:    pulse,
            sense_channel:  nxt.sense_sel,
            rising_edge:    nxt.edge_sel,
            deadline:       nxt.deadline,
            restart_timer:  restart,
            arm_check:      arm,
            speed_estimate: nxt.speed_avg,
            fault_led:      nxt.led,
            mode:           nxt.mode
        };
    end

endmodule

// File: hw/rtl/sbc_out_stage.sv
// ----------------------------------------------------------------------------
// sbc_out_stage
// Result register between the event logic and the output stream; takes a new
// word whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module sbc_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  sbc_pkg::result_t                  result,
    output logic                              can_load,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int RES_W = $bits(sbc_pkg::result_t);

    sbc_pkg::result_t data_reg;
    logic             valid_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {
        {(sbc_pkg::OUT_DATA_W - RES_W){1'b0}},
        data_reg.mode,
        data_reg.fault_led,
        data_reg.speed_estimate,
        data_reg.arm_check,
        data_reg.restart_timer,
        data_reg.deadline,
        data_reg.rising_edge,
        data_reg.sense_channel,
        data_reg.pulse_width,
        data_reg.low_leg_mask,
        data_reg.high_leg_mask,
        data_reg.phase_step
    };

endmodule

// File: hw/rtl/sensorless_bldc_commutator_core.sv
// ----------------------------------------------------------------------------
// sensorless_bldc_commutator_core
// Six-step sensorless BLDC commutation sequencer driven by timing events.
// ----------------------------------------------------------------------------
// Takes one event word per clock: each accepted word updates the commutation
// state at once and its result word is valid on the master side the next
// cycle, so a word may follow every cycle. The single result register sets
// that rate; s_tready follows m_tready combinationally when that register is
// full. Configuration writes are taken every cycle; a write to the start mode
// register also reloads the mode (test or waiting for zero cross).
module sensorless_bldc_commutator_core #(
    parameter int TIMER_WIDTH = sbc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sbc_pkg::IN_DATA_W-1:0]      s_tdata,   // elapsed_ticks, timer_wrapped
    input  logic [1:0]                         s_tuser,   // kind

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phase_step, high_leg_mask, low_leg_mask, pulse_width, sense_channel,
    // rising_edge, deadline, restart_timer, arm_check, speed_estimate,
    // fault_led, mode
    output logic [sbc_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sbc_pkg::state_t  state_reg;
    sbc_pkg::state_t  state_next;
    sbc_pkg::state_t  event_state;
    sbc_pkg::result_t result;
    logic [15:0]      ref_period_reg;
    logic [7:0]       power_ceiling_reg;
    logic             accept;
    logic             can_load;
    logic             cfg_write;

    assign s_tready  = can_load;
    assign accept    = s_tvalid && can_load;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    sbc_event_logic #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_event (
        .cur           (state_reg),
        .ref_period    (ref_period_reg),
        .power_ceiling (power_ceiling_reg),
        .kind          (sbc_pkg::kind_t'(s_tuser)),
        .elapsed_ticks (s_tdata[15:0]),
        .timer_wrapped (s_tdata[16]),
        .nxt           (event_state),
        .result        (result)
    );

    sbc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a start mode write reloads the mode on top of any event update
    always_comb
    begin
        state_next = accept ? event_state : state_reg;
        if (cfg_write && (sbc_pkg::cfg_idx_t'(cfg_index) == sbc_pkg::CFG_START_TEST))
            state_next.mode = cfg_data[0] ? sbc_pkg::MODE_TEST : sbc_pkg::MODE_WAIT_CROSS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= sbc_pkg::STATE_RST;
            ref_period_reg    <= sbc_pkg::REF_PERIOD_RST;
            power_ceiling_reg <= sbc_pkg::POWER_CEIL_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (sbc_pkg::cfg_idx_t'(cfg_index))
                    sbc_pkg::CFG_REF_PERIOD: ref_period_reg    <= cfg_data[15:0];
                    sbc_pkg::CFG_POWER_CEIL: power_ceiling_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensorless BLDC commutation sequencer.
// Event words are streamed in with random gaps, result words are drained
// with random stalls, and each result is checked field by field against a
// cycle-free predictor of the commutation state kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        sbc_pkg::kind_t kind;
        logic [15:0]    ticks;
        logic           wrapped;
    } motor_event_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sbc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sbc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = '0;
    logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // bench copy of the configuration and commutation state
    logic [15:0]     cfg_period;
    logic [7:0]      cfg_ceiling;
    sbc_pkg::mode_t  mdl_mode;
    logic [2:0]      mdl_step;
    logic [2:0]      mdl_high;
    logic [2:0]      mdl_low;
    logic [1:0]      mdl_sense;
    logic            mdl_edge;
    logic [7:0]      mdl_power;
    logic [1:0]      mdl_misses;
    logic [15:0]     mdl_deadline;
    logic [15:0]     mdl_speed;
    logic            mdl_led;

    motor_event_t      event_queue[$];
    sbc_pkg::result_t  bridge_words[$];

    motor_event_t drv_event;
    logic         in_fire = 1'b0;
    logic         out_fire = 1'b0;
    int           in_gap = 0;
    int           out_stall = 0;
    bit           in_burst = 1'b0;
    bit           out_burst = 1'b0;

    int n_cycles = 0;
    int n_events = 0;
    int n_words = 0;
    int n_fail = 0;
    int n_cross = 0;
    int n_missed = 0;
    int n_settings = 0;

    sensorless_bldc_commutator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void rotate_bridge();
        logic [11:0] pattern;
        // next step, high legs, low legs, floating phase, rising edge
        case (mdl_step)
            3'd1:    pattern = {3'd2, 3'd1, 3'd4, 2'd1, 1'b0};
            3'd2:    pattern = {3'd3, 3'd2, 3'd4, 2'd0, 1'b1};
            3'd3:    pattern = {3'd4, 3'd2, 3'd1, 2'd2, 1'b0};
            3'd4:    pattern = {3'd5, 3'd4, 3'd1, 2'd1, 1'b1};
            3'd5:    pattern = {3'd0, 3'd4, 3'd2, 2'd0, 1'b0};
            default: pattern = {3'd1, 3'd1, 3'd2, 2'd2, 1'b1};
        endcase
        {mdl_step, mdl_high, mdl_low, mdl_sense, mdl_edge} = pattern;
    endfunction

    function automatic sbc_pkg::result_t advance_commutation(input sbc_pkg::kind_t kind,
                                                             input logic [15:0] ticks,
                                                             input logic wrapped);
        sbc_pkg::result_t r;
        logic [15:0]      t;
        logic [15:0]      thr;
        logic [15:0]      half;
        logic [7:0]       pulse;
        logic             restart;
        logic             arm;
        logic [31:0]      acc;
        pulse = '0;
        restart = 1'b0;
        arm = 1'b0;
        case (kind)
            sbc_pkg::EV_DEADLINE:
            begin
                if (mdl_mode == sbc_pkg::MODE_AFTER_CROSS)
                begin
                    mdl_led = 1'b0;
                    rotate_bridge();
                    mdl_mode = sbc_pkg::MODE_AFTER_SWITCH;
                    restart = 1'b1;
                    arm = 1'b1;
                    if (mdl_misses > 2'd0)
                        mdl_misses = mdl_misses - 2'd1;
                end
                else if (mdl_mode == sbc_pkg::MODE_WAIT_CROSS)
                begin
                    // missed zero cross
                    mdl_led = 1'b1;
                    n_missed++;
                    if (mdl_misses < sbc_pkg::MISS_LIMIT)
                    begin
                        rotate_bridge();
                        mdl_mode = sbc_pkg::MODE_AFTER_SWITCH;
                        restart = 1'b1;
                        arm = 1'b1;
                        mdl_misses = mdl_misses + 2'd1;
                    end
                    else if (mdl_power > 8'd0)
                        mdl_power = mdl_power - 8'd1;
                end
                else if (mdl_mode == sbc_pkg::MODE_TEST)
                begin
                    rotate_bridge();
                    restart = 1'b1;
                    pulse = sbc_pkg::TEST_PULSE;
                end
            end
            sbc_pkg::EV_CHECK:
            begin
                if (mdl_mode == sbc_pkg::MODE_AFTER_SWITCH)
                begin
                    pulse = mdl_power;
                    mdl_mode = sbc_pkg::MODE_WAIT_CONV;
                end
                else if (mdl_mode == sbc_pkg::MODE_PAUSE)
                    mdl_mode = sbc_pkg::MODE_WAIT_CROSS;
            end
            sbc_pkg::EV_CONV:
            begin
                if (mdl_mode == sbc_pkg::MODE_WAIT_CONV)
                begin
                    mdl_mode = sbc_pkg::MODE_PAUSE;
                    arm = 1'b1;
                end
            end
            default:
            begin
                t = wrapped ? 16'd0 : ticks;
                if (mdl_mode == sbc_pkg::MODE_WAIT_CROSS)
                begin
                    n_cross++;
                    thr = cfg_period - sbc_pkg::STARTUP_MARGIN;
                    half = cfg_period >> 1;
                    mdl_mode = sbc_pkg::MODE_AFTER_CROSS;
                    if (t > thr)
                    begin
                        mdl_deadline = t + sbc_pkg::STARTUP_MARGIN;
                        if (mdl_power < cfg_ceiling)
                            mdl_power = mdl_power + 8'd1;
                    end
                    else if (t > half)
                    begin
                        mdl_deadline = cfg_period;
                        if (mdl_power < cfg_ceiling)
                            mdl_power = mdl_power + 8'd1;
                    end
                    else if (t < half)
                    begin
                        mdl_deadline = t + t;
                        if (mdl_power > 8'd0)
                            mdl_power = mdl_power - 8'd1;
                    end
                end
                // running average, every comparator word, no wrap
                acc = {16'd0, mdl_speed} * 32'd7 + {16'd0, mdl_deadline};
                mdl_speed = acc[18:3];
            end
        endcase
        r.phase_step     = mdl_step;
        r.high_leg_mask  = mdl_high;
        r.low_leg_mask   = mdl_low;
        r.pulse_width    = pulse;
        r.sense_channel  = mdl_sense;
        r.rising_edge    = mdl_edge;
        r.deadline       = mdl_deadline;
        r.restart_timer  = restart;
        r.arm_check      = arm;
        r.speed_estimate = mdl_speed;
        r.fault_led      = mdl_led;
        r.mode           = mdl_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Event driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            bridge_words.push_back(advance_commutation(sbc_pkg::kind_t'(s_tuser),
                                                       s_tdata[15:0], s_tdata[16]));
            n_events++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_fire)
            begin
                // word still waiting for s_tready
            end
            else if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (event_queue.size() > 0)
            begin
                drv_event = event_queue.pop_front();
                s_tuser  <= drv_event.kind;
                s_tdata  <= {7'd0, drv_event.wrapped, drv_event.ticks};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    in_burst = !in_burst;
                in_gap = in_burst ? 0 : int'($urandom_range(0, 10));
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 49) == 0)
                    out_burst = !out_burst;
                out_stall = out_burst ? 0 : int'($urandom_range(0, 10));
            end
            if (out_stall > 0)
            begin
                out_stall = out_stall - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        sbc_pkg::result_t want;
        out_fire <= m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bridge_words.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_tdata);
                n_fail++;
            end
            else
            begin
                want = bridge_words.pop_front();
                check_field("phase_step",     16'(want.phase_step),     16'(m_tdata[2:0]));
                check_field("high_leg_mask",  16'(want.high_leg_mask),  16'(m_tdata[5:3]));
                check_field("low_leg_mask",   16'(want.low_leg_mask),   16'(m_tdata[8:6]));
                check_field("pulse_width",    16'(want.pulse_width),    16'(m_tdata[16:9]));
                check_field("sense_channel",  16'(want.sense_channel),  16'(m_tdata[18:17]));
                check_field("rising_edge",    16'(want.rising_edge),    16'(m_tdata[19]));
                check_field("deadline",       want.deadline,            m_tdata[35:20]);
                check_field("restart_timer",  16'(want.restart_timer),  16'(m_tdata[36]));
                check_field("arm_check",      16'(want.arm_check),      16'(m_tdata[37]));
                check_field("speed_estimate", want.speed_estimate,      m_tdata[53:38]);
                check_field("fault_led",      16'(want.fault_led),      16'(m_tdata[54]));
                check_field("mode",           16'(want.mode),           16'(m_tdata[57:55]));
                n_words++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     n_cycles, bridge_words.size());
            $display("sensorless_bldc_commutator_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_event(input sbc_pkg::kind_t kind, input logic [15:0] ticks,
                              input logic wrapped);
        motor_event_t ev;
        ev.kind = kind;
        ev.ticks = ticks;
        ev.wrapped = wrapped;
        event_queue.push_back(ev);
    endtask

    function automatic sbc_pkg::kind_t rand_kind();
        return sbc_pkg::kind_t'(2'($urandom_range(0, 3)));
    endfunction

    // zero-cross time aimed at the deadline/power regions of the current period
    function automatic logic [15:0] cross_ticks(input int late_pct);
        int          thr;
        int          half;
        int          r;
        logic [15:0] pick;
        thr = (int'(cfg_period) - int'(sbc_pkg::STARTUP_MARGIN)) & 32'h0000FFFF;
        half = int'(cfg_period) / 2;
        r = int'($urandom_range(0, 99));
        if (r < 8)
            pick = 16'(half);
        else if (r < 12)
            pick = 16'd0;
        else if (r < 16)
            pick = 16'hFFFF;
        else if (r < 22)
            pick = 16'($urandom_range(0, 65535));
        else if (r < 30)
            pick = 16'(thr + int'($urandom_range(0, 4)) - 2);
        else if ($urandom_range(0, 99) < late_pct)
        begin
            if (thr < 65535 && $urandom_range(0, 1) == 1)
                pick = 16'($urandom_range(thr + 1, 65535));
            else if (thr > half)
                pick = 16'($urandom_range(half + 1, thr));
            else
                pick = 16'(half + 1);
        end
        else if (half > 0)
            pick = 16'($urandom_range(0, half - 1));
        else
            pick = 16'd0;
        return pick;
    endfunction

    // mostly whole commutation cycles; misses, dropped steps and noise mixed in
    task automatic gen_phase(input int n, input int late_pct, input bit test_heavy);
        int made;
        int streak;
        int r;
        made = 0;
        streak = 0;
        while (made < n)
        begin
            r = int'($urandom_range(0, 99));
            if (test_heavy)
            begin
                if (r < 70)
                    push_event(sbc_pkg::EV_DEADLINE, 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)));
                else
                    push_event(rand_kind(), 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)));
                made++;
            end
            else if (r < 10)
            begin
                push_event(rand_kind(), 16'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)));
                made++;
            end
            else
            begin
                if (streak == 0 && $urandom_range(0, 99) < 12)
                    streak = int'($urandom_range(1, 4));
                if (streak > 0)
                begin
                    push_event(sbc_pkg::EV_DEADLINE, 16'($urandom_range(0, 65535)), 1'b0);
                    streak--;
                end
                else
                begin
                    if ($urandom_range(0, 99) < 8)
                        push_event(sbc_pkg::EV_CROSS, 16'($urandom_range(0, 65535)), 1'b1);
                    else
                        push_event(sbc_pkg::EV_CROSS, cross_ticks(late_pct), 1'b0);
                    push_event(sbc_pkg::EV_DEADLINE, 16'($urandom_range(0, 65535)), 1'b0);
                    made++;
                end
                made++;
                if ($urandom_range(0, 19) != 0)
                begin
                    push_event(sbc_pkg::EV_CHECK, 16'($urandom_range(0, 65535)), 1'b0);
                    made++;
                end
                push_event(sbc_pkg::EV_CONV, 16'($urandom_range(0, 65535)), 1'b0);
                push_event(sbc_pkg::EV_CHECK, 16'($urandom_range(0, 65535)), 1'b0);
                made += 2;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sbc_pkg::CFG_REF_PERIOD: cfg_period = val;
            sbc_pkg::CFG_POWER_CEIL: cfg_ceiling = val[7:0];
            sbc_pkg::CFG_START_TEST:
                mdl_mode = val[0] ? sbc_pkg::MODE_TEST : sbc_pkg::MODE_WAIT_CROSS;
            default: ;
        endcase
    endtask

    // block drained: nothing queued, nothing in flight
    task automatic settle();
        while (event_queue.size() != 0 || s_tvalid || bridge_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          ph;
        int          late_pct;
        bit          test_heavy;
        logic [15:0] period;
        logic [7:0]  ceiling;
        logic        test_start;

        cfg_period   = sbc_pkg::REF_PERIOD_RST;
        cfg_ceiling  = sbc_pkg::POWER_CEIL_RST;
        mdl_mode     = sbc_pkg::MODE_TEST;
        mdl_step     = 3'd0;
        mdl_high     = 3'd0;
        mdl_low      = 3'd0;
        mdl_sense    = 2'd0;
        mdl_edge     = 1'b1;
        mdl_power    = sbc_pkg::POWER_RST;
        mdl_misses   = 2'd0;
        mdl_deadline = sbc_pkg::DEADLINE_RST;
        mdl_speed    = 16'd0;
        mdl_led      = 1'b0;

        // test mode out of reset: steps wrap around, crosses only update speed
        for (int i = 0; i < 7; i++)
            push_event(sbc_pkg::EV_DEADLINE, (i % 2 != 0) ? 16'hFFFF : 16'h0000, i == 3);
        push_event(sbc_pkg::EV_CHECK, 16'd5, 1'b0);
        push_event(sbc_pkg::EV_CONV, 16'd5, 1'b0);
        push_event(sbc_pkg::EV_CROSS, 16'hFFFF, 1'b0);
        push_event(sbc_pkg::EV_CROSS, 16'hFFFF, 1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        settle();
        write_reg(sbc_pkg::CFG_START_TEST, 16'd0);
        @(negedge clk);
        cfg_valid <= 1'b0;

        // cross at exactly half period, full cycle
        push_event(sbc_pkg::EV_CROSS, 16'd1000, 1'b0);
        push_event(sbc_pkg::EV_DEADLINE, 16'd0, 1'b0);
        push_event(sbc_pkg::EV_CHECK, 16'd10, 1'b0);
        push_event(sbc_pkg::EV_CONV, 16'd12, 1'b0);
        push_event(sbc_pkg::EV_CHECK, 16'd22, 1'b0);
        // two misses still commutate
        for (int i = 0; i < 2; i++)
        begin
            push_event(sbc_pkg::EV_DEADLINE, 16'd2000, 1'b0);
            push_event(sbc_pkg::EV_CHECK, 16'd10, 1'b0);
            push_event(sbc_pkg::EV_CONV, 16'd12, 1'b0);
            push_event(sbc_pkg::EV_CHECK, 16'd22, 1'b0);
        end
        // further misses lower power down to zero and hold there
        push_event(sbc_pkg::EV_DEADLINE, 16'd2000, 1'b0);
        push_event(sbc_pkg::EV_DEADLINE, 16'd2000, 1'b0);
        // late cross: deadline sum wraps
        push_event(sbc_pkg::EV_CROSS, 16'hFFFF, 1'b0);

        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    period = 16'd2000;
                    ceiling = 8'd150;
                    test_start = 1'b0;
                    late_pct = 55;
                end
                1:
                begin
                    period = 16'd0;
                    ceiling = 8'd255;
                    test_start = 1'b0;
                    late_pct = 70;
                end
                2:
                begin
                    period = 16'hFFFF;
                    ceiling = 8'd0;
                    test_start = 1'b0;
                    late_pct = 50;
                end
                3:
                begin
                    period = 16'd999;
                    ceiling = 8'd1;
                    test_start = 1'b0;
                    late_pct = 40;
                end
                4:
                begin
                    period = 16'd1000;
                    ceiling = 8'd255;
                    test_start = 1'b1;
                    late_pct = 50;
                end
                5:
                begin
                    period = 16'($urandom_range(0, 65535));
                    ceiling = 8'($urandom_range(0, 255));
                    test_start = 1'b0;
                    late_pct = 80;
                end
                6:
                begin
                    period = 16'd3000;
                    ceiling = 8'd200;
                    test_start = 1'b0;
                    late_pct = 90;
                end
                7:
                begin
                    period = 16'($urandom_range(0, 65535));
                    ceiling = 8'($urandom_range(0, 255));
                    test_start = 1'b1;
                    late_pct = 50;
                end
                8:
                begin
                    period = 16'hFFFF;
                    ceiling = 8'd255;
                    test_start = 1'b0;
                    late_pct = 95;
                end
                default:
                begin
                    period = 16'd1;
                    ceiling = 8'd255;
                    test_start = 1'b0;
                    late_pct = 30;
                end
            endcase
            test_heavy = test_start;

            // sender holds off until every result word is back
            settle();
            write_reg(sbc_pkg::CFG_REF_PERIOD, period);
            write_reg(sbc_pkg::CFG_POWER_CEIL, {8'($urandom_range(0, 255)), ceiling});
            write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            write_reg(sbc_pkg::CFG_START_TEST, {15'($urandom_range(0, 32767)), test_start});
            @(negedge clk);
            cfg_valid <= 1'b0;
            n_settings++;

            gen_phase(175, late_pct, test_heavy);
        end

        settle();
        repeat (10) @(posedge clk);

        $display("covered %0d event words and %0d result words over %0d register settings",
                 n_events, n_words, n_settings);
        $display("zero crosses taken: %0d, missed-cross deadlines: %0d", n_cross, n_missed);
        if (n_fail == 0)
            $display("sensorless_bldc_commutator_core regression: pass");
        else
            $display("sensorless_bldc_commutator_core regression: fail");
        $finish;
    end

endmodule
